// ----- rtl/core/mlfd_pkg.sv -----
// Shared types, codes and marker helpers for the marker/length frame deframer.
`default_nettype none

package mlfd_pkg;

    localparam int unsigned MARKER_W = 24;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CFG_INDEX_W = 2;

    localparam logic [MARKER_W-1:0] START_MARKER_RESET = 24'h667776;
    localparam logic [MARKER_W-1:0] END_MARKER_RESET = 24'h465756;
    localparam logic [BYTE_W-1:0] MARKER_LAST_POS = 8'd2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_START_MARKER = 2'd0,
        CFG_END_MARKER   = 2'd1
    } cfg_index_t;

    typedef enum logic [2:0] {
        PH_SEARCH  = 3'd0,
        PH_START   = 3'd1,
        PH_LENGTH  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_END     = 3'd4,
        PH_DONE    = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        ST_NONE  = 2'd0,
        ST_DONE  = 2'd1,
        ST_ABORT = 2'd2
    } status_t;

    typedef struct packed {
        logic              payload_valid;
        logic [BYTE_W-1:0] payload_byte;
        status_t           frame_status;
    } result_t;

    function automatic logic [BYTE_W-1:0] marker_byte(
        input logic [MARKER_W-1:0] marker,
        input logic [BYTE_W-1:0]   pos
    );
        logic [BYTE_W-1:0] sel;
        sel = '0;
        if (pos == 8'd0)
        begin
            sel = marker[23:16];
        end
        else if (pos == 8'd1)
        begin
            sel = marker[15:8];
        end
        else if (pos == MARKER_LAST_POS)
        begin
            sel = marker[7:0];
        end
        return sel;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/mlfd_parser.sv -----
// Next-state and result logic of the deframer for one item.
`default_nettype none

module mlfd_parser (
    input  wire logic [23:0]          start_marker,
    input  wire logic [23:0]          end_marker,
    input  wire mlfd_pkg::phase_t     phase,
    input  wire logic [7:0]           pos,
    input  wire logic                 command,
    input  wire logic [7:0]           data_byte,
    output mlfd_pkg::phase_t          phase_next,
    output logic [7:0]                pos_next,
    output mlfd_pkg::result_t         result
);
    import mlfd_pkg::*;

    logic       start_hit;
    logic [7:0] pos_inc;

    assign start_hit = (data_byte == marker_byte(start_marker, 8'd0));
    assign pos_inc = pos + 8'd1;

    always_comb
    begin
        phase_next = phase;
        pos_next = pos;
        result.payload_valid = 1'b0;
        result.payload_byte = '0;
        result.frame_status = ST_NONE;

        if (command)
        begin
            if (phase == PH_START || phase == PH_LENGTH || phase == PH_PAYLOAD
                || phase == PH_END)
            begin
                result.frame_status = ST_ABORT;
            end
            phase_next = PH_SEARCH;
            pos_next = '0;
        end
        else
        begin
            unique case (phase)
                PH_START:
                begin
                    if (data_byte == marker_byte(start_marker, pos))
                    begin
                        if (pos_inc > MARKER_LAST_POS)
                        begin
                            phase_next = PH_LENGTH;
                            pos_next = '0;
                        end
                        else
                        begin
                            pos_next = pos_inc;
                        end
                    end
                    else
                    begin
                        result.frame_status = ST_ABORT;
                        phase_next = start_hit ? PH_START : PH_SEARCH;
                        pos_next = start_hit ? 8'd1 : 8'd0;
                    end
                end
                PH_LENGTH:
                begin
                    pos_next = data_byte;
                    phase_next = PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    if (pos != 8'd0)
                    begin
                        pos_next = pos - 8'd1;
                        result.payload_valid = 1'b1;
                        result.payload_byte = data_byte;
                    end
                    else if (data_byte == marker_byte(end_marker, 8'd0))
                    begin
                        phase_next = PH_END;
                        pos_next = 8'd1;
                    end
                    else
                    begin
                        result.frame_status = ST_ABORT;
                        phase_next = start_hit ? PH_START : PH_SEARCH;
                        pos_next = start_hit ? 8'd1 : 8'd0;
                    end
                end
                PH_END:
                begin
                    if (data_byte == marker_byte(end_marker, pos))
                    begin
                        if (pos_inc > MARKER_LAST_POS)
                        begin
                            phase_next = PH_DONE;
                            pos_next = '0;
                            result.frame_status = ST_DONE;
                        end
                        else
                        begin
                            pos_next = pos_inc;
                        end
                    end
                    else
                    begin
                        result.frame_status = ST_ABORT;
                        phase_next = start_hit ? PH_START : PH_SEARCH;
                        pos_next = start_hit ? 8'd1 : 8'd0;
                    end
                end
                PH_DONE:
                begin
                    phase_next = PH_DONE;
                end
                default:
                begin
                    phase_next = start_hit ? PH_START : PH_SEARCH;
                    pos_next = start_hit ? 8'd1 : 8'd0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/marker_length_frame_deframer.sv -----
// Top level of the marker/length frame deframer with input, state and result registers.
// The block takes one item per cycle, unless the receiver stalls, on the input channel
// (in_valid/in_ready) carrying a command bit and a stream byte, and returns exactly one
// result item per input item on the output channel (out_valid/out_ready): a payload byte
// with its valid flag, a frame status and the frame_done flag. Each item is held in an
// input register, goes through the parser logic and lands in the result register, where it
// is presented. Throughput is one item per cycle while the receiver keeps up, set by the
// parser phase and position registers updating with each item.
// When the receiver stalls, the result register holds its item and the input register holds
// the next one; in_ready drops only when both are full.
// The marker registers are written through the cfg channel (cfg_valid/cfg_ready, index 0
// for the start marker, index 1 for the end marker); other indexes are accepted and
// ignored. Writes are always accepted and should only be made while no item is in flight.
// Reset clears both channels, returns the parser to start-marker search and loads the
// default markers "fwv" and "FWV".
`default_nettype none

module marker_length_frame_deframer (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [mlfd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [mlfd_pkg::MARKER_W-1:0]     cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              command,
    input  wire logic [7:0]                        data_byte,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   payload_valid,
    output logic [7:0]                             payload_byte,
    output logic [1:0]                             frame_status,
    output logic                                   frame_done
);
    import mlfd_pkg::*;

    logic [MARKER_W-1:0] start_marker_reg;
    logic [MARKER_W-1:0] end_marker_reg;
    logic                in_valid_reg;
    logic                in_command_reg;
    logic [7:0]          in_data_reg;
    phase_t              phase_reg;
    phase_t              phase_next;
    logic [7:0]          pos_reg;
    logic [7:0]          pos_next;
    result_t             result_next;
    result_t             result_reg;
    logic                done_reg;
    logic                out_valid_reg;
    logic                advance;

    assign cfg_ready = 1'b1;
    assign advance = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    mlfd_parser u_parser (
        .start_marker (start_marker_reg),
        .end_marker   (end_marker_reg),
        .phase        (phase_reg),
        .pos          (pos_reg),
        .command      (in_command_reg),
        .data_byte    (in_data_reg),
        .phase_next   (phase_next),
        .pos_next     (pos_next),
        .result       (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= START_MARKER_RESET;
            end_marker_reg <= END_MARKER_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_START_MARKER)
            begin
                start_marker_reg <= cfg_data;
            end
            else if (cfg_index == CFG_END_MARKER)
            begin
                end_marker_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            phase_reg <= PH_SEARCH;
            pos_reg <= '0;
            out_valid_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                phase_reg <= phase_next;
                pos_reg <= pos_next;
                done_reg <= (phase_next == PH_DONE);
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_command_reg <= command;
            in_data_reg <= data_byte;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign payload_valid = result_reg.payload_valid;
    assign payload_byte = result_reg.payload_byte;
    assign frame_status = result_reg.frame_status;
    assign frame_done = done_reg;

endmodule

`default_nettype wire
